// ===== rtl/core/hhss_pkg.sv =====
package hhss_pkg;

  // Fixed-point format of heights and coordinates.
  localparam int FRAC_BITS = 8;
  localparam int ONE_FX    = 1 << FRAC_BITS;

  // Field widths.
  localparam int IDX_W    = 16;
  localparam int HEIGHT_W = 20;
  localparam int COORD_W  = 24;
  localparam int SLOPE_W  = 17;
  localparam int MS_W     = 9;

  localparam logic [MS_W-1:0] MS_RESET = 9'd202;

  // Stream word layout.
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 2;
  localparam int IDX_LSB   = 0;
  localparam int LH_LSB    = IDX_LSB + IDX_W;
  localparam int QX_LSB    = LH_LSB + HEIGHT_W;
  localparam int QZ_LSB    = QX_LSB + COORD_W;

  // Map space.
  localparam int MAP_OFFSET = 33;
  localparam int XM_W       = COORD_W + 1;
  localparam int CELL_W     = COORD_W - FRAC_BITS;

  // Neighborhood reads.
  localparam int READS    = 8;
  localparam int RD_CNT_W = 4;

  // Interpolation datapath.
  localparam int VAL_W = HEIGHT_W + 1;
  localparam int DIF_W = VAL_W + 1;
  localparam int WGT_W = FRAC_BITS + 2;
  localparam int PRD_W = DIF_W + WGT_W;
  localparam int ACC_W = PRD_W + 2;

  // Normal computation: squares, divider, square root, corner factor.
  localparam int SQ_W       = 2 * VAL_W;
  localparam int DEN_W      = SQ_W;
  localparam int DIV_LAST   = 32 + 2 * FRAC_BITS;
  localparam int DCNT_W     = $clog2(DIV_LAST + 1);
  localparam int QUO_W      = 33;
  localparam int ROOT_W     = QUO_W + 1;
  localparam int ROOT_STEPS = 17;
  localparam int RCNT_W     = 5;
  localparam int NY_W       = 17;
  localparam int E_W        = 18;
  localparam int ESQ_W      = 33;

  localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << (2 * FRAC_BITS);

  localparam int H_MAX     = 524287;
  localparam int H_MIN     = -524288;
  localparam int SLOPE_ONE = 65536;

  localparam logic [HEIGHT_W-1:0] HEIGHT_OFF = HEIGHT_W'(-ONE_FX);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_READ,
    ST_HMUL,
    ST_HADD,
    ST_SQ,
    ST_SUM,
    ST_DIV,
    ST_SQRT,
    ST_ESQ,
    ST_FAC,
    ST_SMUL,
    ST_SADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_we;
    logic latch;
    logic calc_base;
    logic rd_step;
    logic sq;
    logic sum;
    logic div_step;
    logic sqrt_step;
    logic esq;
    logic fac;
    logic imul;
    logic iadd;
    logic slope_sel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rd_last;
    logic div_last;
    logic sqrt_last;
    logic corner_last;
    logic slope_ok;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/hhss_ram.sv =====
module hhss_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hhss_ctrl.sv =====
module hhss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  hhss_pkg::op_e  op_i,
  output logic           s_tready_o,
  output hhss_pkg::cmd_t cmd_o,
  input  hhss_pkg::sts_t sts_i
);

  import hhss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i && (op_i == OP_QUERY)) state_d = ST_BASE;
      end
      ST_BASE: state_d = ST_READ;
      ST_READ: begin
        if (sts_i.rd_last) state_d = ST_HMUL;
      end
      ST_HMUL: state_d = ST_HADD;
      ST_HADD: state_d = sts_i.slope_ok ? ST_SQ : ST_DONE;
      ST_SQ:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sts_i.sqrt_last) state_d = ST_ESQ;
      end
      ST_ESQ:  state_d = ST_FAC;
      ST_FAC:  state_d = sts_i.corner_last ? ST_SMUL : ST_SQ;
      ST_SMUL: state_d = ST_SADD;
      ST_SADD: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (op_i == OP_QUERY) begin
            cmd_o.latch = 1'b1;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_BASE: cmd_o.calc_base = 1'b1;
      ST_READ: cmd_o.rd_step = 1'b1;
      ST_HMUL: cmd_o.imul = 1'b1;
      ST_HADD: cmd_o.iadd = 1'b1;
      ST_SQ:   cmd_o.sq = 1'b1;
      ST_SUM:  cmd_o.sum = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_SQRT: cmd_o.sqrt_step = 1'b1;
      ST_ESQ:  cmd_o.esq = 1'b1;
      ST_FAC:  cmd_o.fac = 1'b1;
      ST_SMUL: begin
        cmd_o.imul      = 1'b1;
        cmd_o.slope_sel = 1'b1;
      end
      ST_SADD: begin
        cmd_o.iadd      = 1'b1;
        cmd_o.slope_sel = 1'b1;
      end
      ST_DONE: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/core/hhss_dp.sv =====
module hhss_dp #(
  parameter int MAP_DIM = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hhss_pkg::MS_W-1:0]            cfg_data_i,
  input  logic [hhss_pkg::IDX_W-1:0]           load_index_i,
  input  logic signed [hhss_pkg::HEIGHT_W-1:0] load_height_i,
  input  logic signed [hhss_pkg::COORD_W-1:0]  query_x_i,
  input  logic signed [hhss_pkg::COORD_W-1:0]  query_z_i,
  input  hhss_pkg::cmd_t                       cmd_i,
  output hhss_pkg::sts_t                       sts_o,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [hhss_pkg::M_TDATA_W-1:0]       m_tdata_o,
  output logic [hhss_pkg::M_TUSER_W-1:0]       m_tuser_o
);

  import hhss_pkg::*;

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int MSW   = $clog2(MAP_DIM + 1);
  localparam int BW    = CELL_W + MSW + 1;
  localparam int PAD_W = M_TDATA_W - HEIGHT_W - SLOPE_W;

  // Configuration and effective map size.
  logic [MS_W-1:0] ms_q;
  logic [MSW-1:0]  eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MS_RESET;
    end else if (cfg_we_i) begin
      ms_q <= cfg_data_i;
    end
  end

  assign eff = (32'(ms_q) > 32'(MAP_DIM)) ? MSW'(MAP_DIM) : MSW'(ms_q);

  // Query split into cell and fraction.
  logic signed [XM_W-1:0] xm, zm;
  logic [CELL_W-1:0]      col, row, col_q, row_q;
  logic [FRAC_BITS-1:0]   dx_q, dz_q;
  logic                   hok, sok, hok_q, sok_q;

  assign xm  = XM_W'(query_x_i) + XM_W'(MAP_OFFSET * ONE_FX);
  assign zm  = XM_W'(query_z_i) + XM_W'(MAP_OFFSET * ONE_FX);
  assign col = xm[XM_W-2:FRAC_BITS];
  assign row = zm[XM_W-2:FRAC_BITS];
  assign hok = !xm[XM_W-1] && !zm[XM_W-1] &&
               (32'(col) + 32'd1 < 32'(eff)) && (32'(row) + 32'd1 < 32'(eff));
  assign sok = !xm[XM_W-1] && !zm[XM_W-1] &&
               (32'(col) + 32'd2 < 32'(eff)) && (32'(row) + 32'd2 < 32'(eff));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      col_q <= col;
      row_q <= row;
      dx_q  <= xm[FRAC_BITS-1:0];
      dz_q  <= zm[FRAC_BITS-1:0];
      hok_q <= hok;
      sok_q <= sok;
    end
  end

  // Neighborhood address generation over a single-port store.
  logic [BW-1:0]       base_full;
  logic [AW-1:0]       base_q, eff_a, off, rd_addr, ram_addr;
  logic [RD_CNT_W-1:0] rd_cnt_q;
  logic                ram_we;
  logic [HEIGHT_W-1:0] ram_rdata;

  assign base_full = BW'(row_q) * BW'(eff) + BW'(col_q);
  assign eff_a     = AW'(eff);

  always_comb begin
    case (rd_cnt_q)
      4'd0:    off = '0;
      4'd1:    off = AW'(1);
      4'd2:    off = AW'(2);
      4'd3:    off = eff_a;
      4'd4:    off = eff_a + AW'(1);
      4'd5:    off = eff_a + AW'(2);
      4'd6:    off = eff_a << 1;
      4'd7:    off = (eff_a << 1) + AW'(1);
      default: off = '0;
    endcase
  end

  assign rd_addr  = base_q + off;
  assign ram_addr = cmd_i.load_we ? AW'(32'(load_index_i)) : rd_addr;
  assign ram_we   = cmd_i.load_we && (32'(load_index_i) < 32'(DEPTH));

  hhss_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (load_height_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_base) begin
      base_q <= AW'(base_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
    end else if (cmd_i.calc_base) begin
      rd_cnt_q <= '0;
    end else if (cmd_i.rd_step) begin
      rd_cnt_q <= rd_cnt_q + RD_CNT_W'(1);
    end
  end

  // Heights of the 3x3 neighborhood minus its far corner, row by row.
  logic signed [HEIGHT_W-1:0] h_q [READS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_step && (rd_cnt_q != '0)) begin
      h_q[3'(rd_cnt_q - RD_CNT_W'(1))] <= ram_rdata;
    end
  end

  // Corner normal: squares of the two height differences.
  logic [1:0]                 corner_q;
  logic signed [HEIGHT_W-1:0] hp, hq, hr;
  logic signed [VAL_W-1:0]    d1, d2;
  logic signed [SQ_W-1:0]     sq1, sq2;
  logic [SQ_W-1:0]            sq1_q, sq2_q;

  always_comb begin
    case (corner_q)
      2'd0: begin
        hp = h_q[0]; hq = h_q[1]; hr = h_q[3];
      end
      2'd1: begin
        hp = h_q[1]; hq = h_q[2]; hr = h_q[4];
      end
      2'd2: begin
        hp = h_q[3]; hq = h_q[4]; hr = h_q[6];
      end
      default: begin
        hp = h_q[4]; hq = h_q[5]; hr = h_q[7];
      end
    endcase
  end

  assign d1  = VAL_W'(hp) - VAL_W'(hq);
  assign d2  = VAL_W'(hp) - VAL_W'(hr);
  assign sq1 = d1 * d1;
  assign sq2 = d2 * d2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      sq1_q <= sq1;
      sq2_q <= sq2;
    end
  end

  // Restoring divider, one quotient bit per cycle: floor(2^DIV_LAST / den).
  logic [DEN_W-1:0]  den_q, rem_q, rem_d;
  logic [DEN_W:0]    rem_sh, rem_diff;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              div_ge, div_last;

  assign rem_sh   = {rem_q, (div_cnt_q == '0)};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign div_ge   = rem_sh >= {1'b0, den_q};
  assign rem_d    = div_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign quo_d    = {quo_q[QUO_W-2:0], div_ge};
  assign div_last = div_cnt_q == DCNT_W'(DIV_LAST);

  // Bitwise square root of the quotient, two radicand bits per cycle.
  logic [QUO_W-1:0]  rv_q;
  logic [ROOT_W-1:0] res_q, bit_q, trial;
  logic [RCNT_W-1:0] root_cnt_q;
  logic              root_ge, sqrt_last;

  assign trial     = res_q + bit_q;
  assign root_ge   = ROOT_W'(rv_q) >= trial;
  assign sqrt_last = root_cnt_q == RCNT_W'(ROOT_STEPS - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      den_q <= DEN_ONE + sq1_q + sq2_q;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.div_step && div_last) begin
      rv_q  <= quo_d;
      res_q <= '0;
      bit_q <= ROOT_W'(1) << (QUO_W - 1);
    end else if (cmd_i.sqrt_step) begin
      rv_q  <= root_ge ? QUO_W'(ROOT_W'(rv_q) - trial) : rv_q;
      res_q <= root_ge ? (res_q >> 1) + bit_q : res_q >> 1;
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q  <= '0;
      root_cnt_q <= '0;
    end else begin
      if (cmd_i.sum) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DCNT_W'(1);
      end
      if (cmd_i.div_step && div_last) begin
        root_cnt_q <= '0;
      end else if (cmd_i.sqrt_step) begin
        root_cnt_q <= root_cnt_q + RCNT_W'(1);
      end
    end
  end

  // Corner factor ((2*ny - 1)^2) with ny in 16 fraction bits.
  logic [E_W:0]            e_u;
  logic signed [E_W-1:0]   e_s;
  logic signed [2*E_W-1:0] ee;
  logic [ESQ_W-1:0]        ee_q;
  logic [ESQ_W:0]          fac_sum;
  logic [SLOPE_W-1:0]      fac_q [4];

  assign e_u     = {1'b0, res_q[NY_W-1:0], 1'b0} - (E_W + 1)'(SLOPE_ONE);
  assign e_s     = e_u[E_W-1:0];
  assign ee      = e_s * e_s;
  assign fac_sum = {1'b0, ee_q} + (ESQ_W + 1)'(1 << 15);

  always_ff @(posedge clk_i) begin
    if (cmd_i.esq) begin
      ee_q <= ee[ESQ_W-1:0];
    end
    if (cmd_i.fac) begin
      fac_q[corner_q] <= fac_sum[16 +: SLOPE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
    end else if (cmd_i.iadd && !cmd_i.slope_sel) begin
      corner_q <= '0;
    end else if (cmd_i.fac) begin
      corner_q <= corner_q + 2'd1;
    end
  end

  // Triangle interpolation, shared by height and slope.
  logic signed [VAL_W-1:0] vp, vq, vr, vt, vb, vb_q;
  logic                    upper;
  logic signed [WGT_W-1:0] w1, w2;
  logic signed [DIF_W-1:0] da, db;
  logic signed [PRD_W-1:0] p1, p2, p1_q, p2_q;
  logic signed [ACC_W-1:0] acc, val, hsat, ssat;

  always_comb begin
    if (cmd_i.slope_sel) begin
      vp = VAL_W'(fac_q[0]);
      vq = VAL_W'(fac_q[1]);
      vr = VAL_W'(fac_q[2]);
      vt = VAL_W'(fac_q[3]);
    end else begin
      vp = VAL_W'(h_q[0]);
      vq = VAL_W'(h_q[1]);
      vr = VAL_W'(h_q[3]);
      vt = VAL_W'(h_q[4]);
    end
  end

  assign upper = ({1'b0, dx_q} + {1'b0, dz_q}) < (FRAC_BITS + 1)'(ONE_FX);
  assign w1    = upper ? WGT_W'(dx_q) : WGT_W'(ONE_FX) - WGT_W'(dx_q);
  assign w2    = upper ? WGT_W'(dz_q) : WGT_W'(ONE_FX) - WGT_W'(dz_q);
  assign da    = upper ? DIF_W'(vq) - DIF_W'(vp) : DIF_W'(vr) - DIF_W'(vt);
  assign db    = upper ? DIF_W'(vr) - DIF_W'(vp) : DIF_W'(vq) - DIF_W'(vt);
  assign vb    = upper ? vp : vt;
  assign p1    = w1 * da;
  assign p2    = w2 * db;

  always_ff @(posedge clk_i) begin
    if (cmd_i.imul) begin
      p1_q <= p1;
      p2_q <= p2;
      vb_q <= vb;
    end
  end

  // Round to nearest with ties upward: add one half, then floor.
  assign acc = ACC_W'(p1_q) + ACC_W'(p2_q) + ACC_W'(ONE_FX / 2);
  assign val = (acc >>> FRAC_BITS) + ACC_W'(vb_q);

  always_comb begin
    if (val > ACC_W'(H_MAX)) begin
      hsat = ACC_W'(H_MAX);
    end else if (val < ACC_W'(H_MIN)) begin
      hsat = ACC_W'(H_MIN);
    end else begin
      hsat = val;
    end
    if (val > ACC_W'(SLOPE_ONE)) begin
      ssat = ACC_W'(SLOPE_ONE);
    end else if (val < ACC_W'(0)) begin
      ssat = '0;
    end else begin
      ssat = val;
    end
  end

  logic [HEIGHT_W-1:0] hres_q;
  logic [SLOPE_W-1:0]  sres_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      hres_q <= HEIGHT_OFF;
      sres_q <= '0;
    end else if (cmd_i.iadd) begin
      if (cmd_i.slope_sel) begin
        sres_q <= SLOPE_W'(ssat);
      end else if (hok_q) begin
        hres_q <= HEIGHT_W'(hsat);
      end
    end
  end

  // Output register: the result word waits here while new words are taken.
  logic                 m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TUSER_W-1:0] m_tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_tdata_q <= {{PAD_W{1'b0}}, sres_q, hres_q};
      m_tuser_q <= {sok_q, hok_q};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  assign sts_o.rd_last     = rd_cnt_q == RD_CNT_W'(READS);
  assign sts_o.div_last    = div_last;
  assign sts_o.sqrt_last   = sqrt_last;
  assign sts_o.corner_last = corner_q == 2'd3;
  assign sts_o.slope_ok    = sok_q;
  assign sts_o.out_free    = !m_tvalid_q || m_tready_i;

endmodule

// ===== rtl/core/heightmap_height_slope_sampler_top.sv =====
// Heightmap sampler. A load word (tuser = 0) writes one height into the map
// store and gives no result. A query word (tuser = 1) gives one result word:
// the height interpolated over the cell triangle under the point and a slope
// factor interpolated from the four cell corners, each with an in-map flag. A
// query reads eight store entries one per cycle from the single-port store
// and, when its slope neighborhood lies on the map, then forms the four corner
// normals one after another on one divider and one square-root unit (a
// bit-serial divide of 2*FRAC_BITS+33 steps and a 17-step root). The store is
// not cleared at reset; every entry a query touches must have been loaded.
// The user must write map_size only while no query is in flight; the block
// itself does not enforce this.
module heightmap_height_slope_sampler_top #(
  parameter int MAP_DIM = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // s_tdata: load_index[15:0], load_height[35:16], query_x[59:36], query_z[83:60]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [hhss_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: op
  input  logic                             s_tuser,
  // m_tdata: height_out[19:0], slope_out[36:20]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [hhss_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser: height_ok[0], slope_ok[1]
  output logic [hhss_pkg::M_TUSER_W-1:0]   m_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hhss_pkg::MS_W-1:0]        cfg_data_i
);

  import hhss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  hhss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .op_i       (op_e'(s_tuser)),
    .s_tready_o (s_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hhss_dp #(
    .MAP_DIM (MAP_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .load_index_i  (s_tdata[IDX_LSB +: IDX_W]),
    .load_height_i (s_tdata[LH_LSB +: HEIGHT_W]),
    .query_x_i     (s_tdata[QX_LSB +: COORD_W]),
    .query_z_i     (s_tdata[QZ_LSB +: COORD_W]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_tready_i    (m_tready),
    .m_tvalid_o    (m_tvalid),
    .m_tdata_o     (m_tdata),
    .m_tuser_o     (m_tuser)
  );

endmodule

// ===== rtl/core/hhss_checker.sv =====
module hhss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [hhss_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [hhss_pkg::M_TUSER_W-1:0] m_tuser
);

  import hhss_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_height_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[0] |-> m_tdata[HEIGHT_W-1:0] == HEIGHT_OFF)
    else $error("off-map height is not minus one");

  a_slope_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[1] |-> m_tdata[HEIGHT_W +: SLOPE_W] == '0)
    else $error("off-map slope is not zero");

  a_slope_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[1] |->
      m_tuser[0] && (m_tdata[HEIGHT_W +: SLOPE_W] <= SLOPE_W'(SLOPE_ONE)))
    else $error("slope valid outside height cell or above one");

endmodule

bind heightmap_height_slope_sampler_top hhss_checker u_hhss_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/tb_heightmap_height_slope_sampler_top.sv =====
module tb_heightmap_height_slope_sampler_top;
  import hhss_pkg::*;

  typedef struct {
    logic [HEIGHT_W-1:0] height;
    logic                height_ok;
    logic [SLOPE_W-1:0]  slope;
    logic                slope_ok;
  } sample_t;

  class slope_scoreboard;
    int      heights[65536];
    bit      loaded[65536];
    int      map_size;
    int      errors;
    sample_t samples_due[$];

    function new();
      map_size = MS_RESET;
      errors = 0;
    endfunction

    function int edge_len();
      return (map_size > 256) ? 256 : map_size;
    endfunction

    function longint at(longint c, longint w);
      return heights[int'(c + w * edge_len())];
    endfunction

    function bit is_loaded(longint c, longint w);
      return loaded[int'(c + w * edge_len())];
    endfunction

    // True when every entry that the query's result uses has been loaded.
    function bit safe(int x, int z);
      longint xm, zm, c, r;
      int m;
      m = edge_len();
      xm = longint'(x) + (MAP_OFFSET << FRAC_BITS);
      zm = longint'(z) + (MAP_OFFSET << FRAC_BITS);
      if (xm < 0 || zm < 0) return 1;
      c = xm >>> FRAC_BITS;
      r = zm >>> FRAC_BITS;
      if (c + 1 < m && r + 1 < m)
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++)
            if (!is_loaded(c + i, r + j)) return 0;
      if (c + 2 < m && r + 2 < m)
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            if (!(i == 2 && j == 2) && !is_loaded(c + i, r + j)) return 0;
      return 1;
    endfunction

    function longint blend(longint p, longint q, longint r, longint t,
                           longint dx, longint dz);
      longint base, s;
      if (dx + dz < ONE_FX) begin
        base = p;
        s = dx * (q - p) + dz * (r - p);
      end else begin
        base = t;
        s = (ONE_FX - dx) * (r - t) + (ONE_FX - dz) * (q - t);
      end
      return base + ((s + (ONE_FX / 2)) >>> FRAC_BITS);
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, trial;
      res = 0;
      for (int b = 20; b >= 0; b--) begin
        trial = res | (64'd1 << b);
        if (trial * trial <= v) res = trial;
      end
      return res;
    endfunction

    // Squared and rescaled normal y at one corner, 16 fraction bits.
    function longint flatness(longint c, longint w);
      longint hp, d1, d2, e;
      longint unsigned den, ny;
      hp = at(c, w);
      d1 = hp - at(c + 1, w);
      d2 = hp - at(c, w + 1);
      den = (64'd1 << (2 * FRAC_BITS)) + d1 * d1 + d2 * d2;
      ny = root_floor((64'd1 << (32 + 2 * FRAC_BITS)) / den);
      e = 2 * longint'(ny) - SLOPE_ONE;
      return (e * e + 32768) >>> 16;
    endfunction

    function void note_load(int idx, int h);
      heights[idx] = h;
      loaded[idx] = 1;
    endfunction

    function void note_query(int x, int z);
      sample_t s;
      longint xm, zm, c, r, dx, dz, v;
      int m;
      m = edge_len();
      s.height = HEIGHT_OFF;
      s.height_ok = 0;
      s.slope = '0;
      s.slope_ok = 0;
      xm = longint'(x) + (MAP_OFFSET << FRAC_BITS);
      zm = longint'(z) + (MAP_OFFSET << FRAC_BITS);
      if (xm >= 0 && zm >= 0) begin
        c = xm >>> FRAC_BITS;
        r = zm >>> FRAC_BITS;
        dx = xm & (ONE_FX - 1);
        dz = zm & (ONE_FX - 1);
        if (c + 1 < m && r + 1 < m) begin
          v = blend(at(c, r), at(c + 1, r), at(c, r + 1), at(c + 1, r + 1), dx, dz);
          if (v > H_MAX) v = H_MAX;
          if (v < H_MIN) v = H_MIN;
          s.height = HEIGHT_W'(v);
          s.height_ok = 1;
        end
        if (c + 2 < m && r + 2 < m) begin
          v = blend(flatness(c, r), flatness(c + 1, r), flatness(c, r + 1),
                    flatness(c + 1, r + 1), dx, dz);
          if (v > SLOPE_ONE) v = SLOPE_ONE;
          if (v < 0) v = 0;
          s.slope = SLOPE_W'(v);
          s.slope_ok = 1;
        end
      end
      samples_due.push_back(s);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check(logic [M_TDATA_W-1:0] d, logic [M_TUSER_W-1:0] u);
      sample_t s;
      if (samples_due.size() == 0) begin
        report($sformatf("result word with none pending, tdata %h", d));
        return;
      end
      s = samples_due.pop_front();
      if (d[19:0] !== s.height)
        report($sformatf("height %h, predicted %h", d[19:0], s.height));
      if (u[0] !== s.height_ok)
        report($sformatf("height_ok %b, predicted %b", u[0], s.height_ok));
      if (d[36:20] !== s.slope)
        report($sformatf("slope %h, predicted %h", d[36:20], s.slope));
      if (u[1] !== s.slope_ok)
        report($sformatf("slope_ok %b, predicted %b", u[1], s.slope_ok));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [MS_W-1:0]       cfg_data_i;

  slope_scoreboard sb = new();
  bit quiet;
  int ready_hold;
  int pc, pr, psz;

  heightmap_height_slope_sampler_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    clk_i = 0;
    rst_ni = 0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = OP_LOAD;
    m_tready = 0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    quiet = 0;
    ready_hold = 0;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      if (s_tuser == OP_QUERY)
        sb.note_query($signed(s_tdata[59:36]), $signed(s_tdata[83:60]));
      else
        sb.note_load(s_tdata[15:0], $signed(s_tdata[35:16]));
    end
    if (rst_ni && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
  end

  // Receiver stalls: tready drops at random unless quiet is set.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_tready <= 0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1;
    end
  end

  task automatic send_word(op_e op, int idx, int h, int x, int z);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {4'b0, 24'(z), 24'(x), 20'(h), 16'(idx)};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // The last word was taken at the previous edge, so tvalid drops first.
  task automatic wait_idle();
    s_tvalid <= 0;
    while (sb.samples_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_map_size(int v);
    wait_idle();
    cfg_valid_i <= 1;
    cfg_data_i <= MS_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.map_size = v;
  endtask

  function automatic int pick_height(int mode, int k);
    case (mode)
      0: return $urandom_range(0, 1200) - 600;
      1: return int'($signed(20'($urandom)));
      default: return (k[0] ^ $urandom_range(0, 1)) ? H_MAX : H_MIN;
    endcase
  endfunction

  task automatic load_here(int c, int r, int mode);
    send_word(OP_LOAD, c + r * sb.edge_len(), pick_height(mode, c + r),
              $urandom, $urandom);
  endtask

  task automatic query_at(int x, int z);
    if (sb.safe(x, z)) send_word(OP_QUERY, $urandom, $urandom, x, z);
  endtask

  task automatic rand_query(bit noise);
    int x, z, c, r, dx, dz;
    for (int t = 0; t < 20; t++) begin
      if (noise) begin
        x = int'($signed(24'($urandom)));
        z = int'($signed(24'($urandom)));
      end else begin
        c = pc + $urandom_range(0, psz);
        r = pr + $urandom_range(0, psz);
        dx = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
          0: dz = (256 - dx) & 255;
          1: dz = 255 - dx;
          default: dz = $urandom_range(0, 255);
        endcase
        x = ((c - MAP_OFFSET) << FRAC_BITS) + dx;
        z = ((r - MAP_OFFSET) << FRAC_BITS) + dz;
      end
      if (sb.safe(x, z)) begin
        send_word(OP_QUERY, $urandom, $urandom, x, z);
        return;
      end
    end
    query_at((pc - MAP_OFFSET) << FRAC_BITS, (pr - MAP_OFFSET) << FRAC_BITS);
  endtask

  task automatic run_phase(int ms_val, bit do_write, int mode, int n_rand, bit directed);
    int m, bx, bz, sel;
    if (do_write) write_map_size(ms_val);
    m = sb.edge_len();
    psz = (m < 8) ? m : 8;
    case ($urandom_range(0, 2))
      0: pc = 0;
      1: pc = m - psz;
      default: pc = $urandom_range(0, m - psz);
    endcase
    pr = directed ? m - psz : $urandom_range(0, m - psz);
    if (directed) pc = m - psz;
    for (int r = 0; r < psz; r++)
      for (int c = 0; c < psz; c++) load_here(pc + c, pr + r, mode);
    if (directed) begin
      bx = (pc - MAP_OFFSET) << FRAC_BITS;
      bz = (pr - MAP_OFFSET) << FRAC_BITS;
      query_at(bx, bz);
      query_at(bx + 255, bz);
      query_at(bx + 128, bz + 128);
      query_at(bx + 127, bz + 128);
      query_at(bx + 255, bz + 255);
      // Points near the far edges: height cells and slope neighborhoods that just fit or run off the map.
      query_at(((m - 2 - MAP_OFFSET) << FRAC_BITS) + 77, bz + 40);
      query_at(bx + 3, ((m - 2 - MAP_OFFSET) << FRAC_BITS) + 200);
      query_at(((m - 3 - MAP_OFFSET) << FRAC_BITS) + 255,
               ((m - 3 - MAP_OFFSET) << FRAC_BITS) + 255);
      query_at(((m - 1 - MAP_OFFSET) << FRAC_BITS), bz);
      // Points just left of map space and at the coordinate extremes.
      query_at(-(MAP_OFFSET << FRAC_BITS) - 1, bz);
      query_at(bx, -(MAP_OFFSET << FRAC_BITS) - 1);
      query_at(8388607, 8388607);
      query_at(-8388608, -8388608);
      query_at(8388607, -8388608);
      query_at(-8388608, bz);
      send_word(OP_LOAD, pc + 1 + (pr + 1) * m, H_MAX, 0, 0);
      send_word(OP_LOAD, pc + 2 + (pr + 1) * m, H_MIN, -1, -1);
      query_at(bx + 256 + 10, bz + 256 + 20);
      query_at(bx + 256 + 250, bz + 256 + 250);
      query_at(bx + 10, bz + 30);
    end
    for (int i = 0; i < n_rand; i++) begin
      if (i == n_rand / 2) wait_idle();
      sel = $urandom_range(0, 99);
      if (sel < 65) rand_query(0);
      else if (sel < 75) rand_query(1);
      else if (sel < 90)
        load_here(pc + $urandom_range(0, psz - 1), pr + $urandom_range(0, psz - 1),
                  $urandom_range(0, 2));
      else
        send_word(OP_LOAD, $urandom_range(0, 65535), pick_height(1, 0), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    run_phase(MS_RESET, 0, 2, 60, 1);
    run_phase(3, 1, 1, 60, 0);
    run_phase(256, 1, 0, 60, 0);
    run_phase(511, 1, 1, 50, 0);
    run_phase(4, 1, 2, 50, 0);
    run_phase($urandom_range(5, 255), 1, 0, 60, 0);
    wait_idle();
    quiet <= 1;
    run_phase(300, 1, 1, 60, 0);
    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
